/* sv/rsc_pkg.sv */
// shared types, codes and constants of the rpn stack calculator
package rsc_pkg;

    localparam int DATA_W            = 32;
    localparam int OP_W              = 3;
    localparam int IDX_W             = 4;
    localparam int CNT_OUT_W         = 5;
    localparam int STATUS_W          = 3;
    localparam int STACK_ENTRIES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_CLEAR = 3'd5,
        OP_PEEK  = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_BADINDEX  = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_value;
        logic [IDX_W-1:0]         peek_index;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [CNT_OUT_W-1:0]     stack_count;
        logic [STATUS_W-1:0]      status;
    } t_rsp;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic sat;
    } t_alu_sts;

endpackage

/* sv/rsc_stream_if.sv */
// valid/ready channel carrying one payload per transaction
interface rsc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/rsc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/rsc_alu.sv */
// shared arithmetic unit: add, subtract, multiply, bit-serial divide, saturation
module rsc_alu #(
    parameter int FRACTION_BITS = rsc_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rsc_pkg::t_alu_ctl                i_ctl,
    input  logic signed [rsc_pkg::DATA_W-1:0] i_lhs,
    input  logic signed [rsc_pkg::DATA_W-1:0] i_rhs,
    output rsc_pkg::t_alu_sts                o_sts,
    output logic signed [rsc_pkg::DATA_W-1:0] o_result
);
    import rsc_pkg::*;

    localparam int DW  = DATA_W + FRACTION_BITS;
    localparam int SCW = $clog2(DW + 1);
    localparam int AW  = 2 * DATA_W;

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_DIV  = 5'b00100,
        A_FIX  = 5'b01000,
        A_SAT  = 5'b10000
    } t_alu_state;

    t_alu_state              r_state, n_state;
    logic signed [AW-1:0]    r_acc;
    logic [DATA_W-1:0]       r_rem;
    logic [DATA_W-1:0]       r_div;
    logic [DW-1:0]           r_quo;
    logic                    r_neg;
    logic [SCW-1:0]          r_step;

    logic [DATA_W-1:0]       lhs_mag;
    logic [DATA_W-1:0]       rhs_mag;
    logic [DATA_W:0]         rem_sh;
    logic [DATA_W+1:0]       diff;
    logic                    fits;
    logic                    in_range;

    assign lhs_mag = i_lhs[DATA_W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign rhs_mag = i_rhs[DATA_W-1] ? (~i_rhs + 1'b1) : i_rhs;

    // one restoring divide step per cycle
    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign fits   = !diff[DATA_W+1];

    assign in_range = (r_acc[AW-1:DATA_W-1] == {(DATA_W+1){r_acc[DATA_W-1]}});

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    case (i_ctl.op)
                        OP_MUL:  n_state = A_MUL;
                        OP_DIV:  n_state = A_DIV;
                        default: n_state = A_SAT;
                    endcase
                end
            end
            A_MUL: n_state = A_SAT;
            A_DIV: begin
                if (r_step == SCW'(1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: n_state = A_SAT;
            A_SAT: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    case (i_ctl.op)
                        OP_ADD: begin
                            r_acc <= {{DATA_W{i_lhs[DATA_W-1]}}, i_lhs}
                                   + {{DATA_W{i_rhs[DATA_W-1]}}, i_rhs};
                        end
                        OP_SUB: begin
                            r_acc <= {{DATA_W{i_lhs[DATA_W-1]}}, i_lhs}
                                   - {{DATA_W{i_rhs[DATA_W-1]}}, i_rhs};
                        end
                        OP_MUL: begin
                            r_acc <= i_lhs * i_rhs;
                        end
                        OP_DIV: begin
                            r_quo  <= DW'(lhs_mag) << FRACTION_BITS;
                            r_rem  <= '0;
                            r_div  <= rhs_mag;
                            r_neg  <= i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1];
                            r_step <= SCW'(DW);
                        end
                        default: begin
                            r_acc <= '0;
                        end
                    endcase
                end
            end
            A_MUL: begin
                // arithmetic shift rounds toward minus infinity
                r_acc <= r_acc >>> FRACTION_BITS;
            end
            A_DIV: begin
                r_rem  <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                r_quo  <= {r_quo[DW-2:0], fits};
                r_step <= r_step - SCW'(1);
            end
            A_FIX: begin
                r_acc <= r_neg ? -$signed(AW'(r_quo)) : $signed(AW'(r_quo));
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done = (r_state == A_SAT);
    assign o_sts.sat  = !in_range;
    assign o_result   = in_range ? r_acc[DATA_W-1:0]
                      : (r_acc[AW-1] ? SAT_MIN : SAT_MAX);
endmodule

/* sv/rpn_stack_calculator_top.sv */
// rpn calculator on a stack of signed fixed-point values, with sequencer and stack ram
//
//  channel  dir  payload                                      handshake
//  i_cmd    in   operation, operand_value, peek_index         valid/ready
//  o_rsp    out  top_value, stack_count, status               valid/ready
//
// push, clear and rejected commands go from decode straight to output; peek also reads the stack ram
// add, subtract and multiply read the ram and run the alu; multiply adds a rescaling shift
// divide runs the alu's one-bit-per-cycle divide loop, then a sign fix and saturation
// i_cmd.ready is high only while the sequencer is idle
// one output register holds the response; a stalled o_rsp delays only the next response
// synchronous active-low reset empties the stack; the stack ram itself is not cleared
module rpn_stack_calculator_top #(
    parameter int STACK_ENTRIES = rsc_pkg::STACK_ENTRIES_DEF,
    parameter int FRACTION_BITS = rsc_pkg::FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsc_stream_if.sink   i_cmd,
    rsc_stream_if.source o_rsp
);
    import rsc_pkg::*;

    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int CW = $clog2(STACK_ENTRIES + 1);
    localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_CALC   = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [OP_W-1:0]          r_op, n_op;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [CW-1:0]            r_count, n_count;
    logic signed [DATA_W-1:0] r_top, n_top;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_shown, n_shown;
    logic                     r_use_shown, n_use_shown;
    logic                     r_out_valid, n_out_valid;
    t_rsp                     r_out, n_out;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    t_alu_ctl                 alu_ctl;
    t_alu_sts                 alu_sts;
    logic signed [DATA_W-1:0] alu_result;

    logic [XW-1:0]            count_x;
    logic [XW-1:0]            peek_pos;
    logic                     full;
    logic                     peek_bad;

    assign count_x  = XW'(r_count);
    assign peek_pos = count_x - XW'(1) - XW'(r_idx);
    assign full     = (r_count == CW'(STACK_ENTRIES));
    assign peek_bad = (XW'(r_idx) >= count_x);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_idx       = r_idx;
        n_count     = r_count;
        n_top       = r_top;
        n_status    = r_status;
        n_shown     = r_shown;
        n_use_shown = r_use_shown;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_count);
        ram_wdata   = r_value;
        ram_re      = 1'b0;
        ram_raddr   = AW'(r_count - CW'(2));
        alu_ctl     = '{start: 1'b0, op: r_op};

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op        = i_cmd.data.operation;
                    n_value     = i_cmd.data.operand_value;
                    n_idx       = i_cmd.data.peek_index;
                    n_status    = ST_OK;
                    n_use_shown = 1'b0;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                case (r_op)
                    OP_PUSH: begin
                        if (full) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            ram_we  = 1'b1;
                            n_top   = r_value;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (r_count < CW'(2)) begin
                            n_status = ST_UNDERFLOW;
                        end else if (r_op == OP_DIV && r_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_PEEK: begin
                        if (peek_bad) begin
                            n_status = ST_BADINDEX;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(peek_pos);
                            n_state   = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                if (r_op == OP_PEEK) begin
                    n_shown     = ram_rdata;
                    n_use_shown = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    alu_ctl.start = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                if (alu_sts.done) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_count - CW'(2));
                    ram_wdata = alu_result;
                    n_top     = alu_result;
                    n_count   = r_count - CW'(1);
                    n_status  = alu_sts.sat ? ST_SATURATED : ST_OK;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.top_value   = r_use_shown ? r_shown
                                      : ((r_count == '0) ? '0 : r_top);
                    n_out.stack_count = count_x[CNT_OUT_W-1:0];
                    n_out.status      = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_top       <= n_top;
        r_status    <= n_status;
        r_shown     <= n_shown;
        r_use_shown <= n_use_shown;
        r_out       <= n_out;
    end

    rsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_ENTRIES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rsc_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_lhs    (ram_rdata),
        .i_rhs    (r_top),
        .o_sts    (alu_sts),
        .o_result (alu_result)
    );
endmodule
